/* src/tdpt_pkg.sv */
// Shared types for the trial-division prime test.
// No dependencies; imported by the top level.
package tdpt_pkg;

    // Sequencer states of the top level
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } tdpt_state_t;

endpackage

/* src/tdpt_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Standalone; instantiated by trial_division_prime_test.
module tdpt_div #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [VALUE_WIDTH-1:0] remainder
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CW-1:0]          cnt_reg;
    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;

    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic                   ge;
    logic [VALUE_WIDTH-1:0] rem_next;

    // One shift-and-subtract step of the shared unit
    always_comb
    begin
        trial    = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        ge       = (trial >= {1'b0, divisor});
        diff     = trial - {1'b0, divisor};
        rem_next = ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(VALUE_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: dividend shifts out of quo_reg as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[VALUE_WIDTH-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* src/trial_division_prime_test.sv */
// Trial-division primality tester: sequencer, divisor register, result register.
// Depends on tdpt_pkg and tdpt_div.
//
//  channel | direction | tdata fields (lowest bit up)       | per item
//  --------+-----------+------------------------------------+----------------
//  s_*     | in        | value                              | one value
//  m_*     | out       | tested_value, is_prime             | one result
//
// Scan: each odd divisor d = 3, 5, 7, ... takes one full pass of the
//   bit-serial divider; the scan stops at the first d with d > value / d or
//   value % d == 0. Values below 4 and even values skip the divider.
// Reset clears the sequencer and the result valid; nothing else needs clearing.
// s_tready is high only in the idle state. A finished result waits in the
//   output register; the next item is accepted while it waits, and its own
//   result holds in the sequencer until the register frees.
module trial_division_prime_test #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // value
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [((VALUE_WIDTH + 8) / 8) * 8 - 1:0] m_tdata   // tested_value, is_prime
);

    import tdpt_pkg::*;

    tdpt_state_t            state_reg, state_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [VALUE_WIDTH-1:0] div_reg, div_next;
    logic                   prime_reg, prime_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic                   out_prime_reg;
    logic                   out_load;

    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [VALUE_WIDTH-1:0] remainder;
    logic [VALUE_WIDTH-1:0] in_value;

    assign in_value = s_tdata[VALUE_WIDTH-1:0];

    // The divider latches its dividend at the start edge, together with value_reg
    tdpt_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (value_next),
        .divisor   (div_reg),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        div_reg   <= div_next;
        prime_reg <= prime_next;
        if (out_load)
        begin
            out_value_reg <= value_reg;
            out_prime_reg <= prime_reg;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        value_next    = value_reg;
        div_next      = div_reg;
        prime_next    = prime_reg;
        div_start     = 1'b0;
        out_load      = 1'b0;
        s_tready      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    value_next = in_value;
                    div_next   = VALUE_WIDTH'(3);
                    if (in_value[VALUE_WIDTH-1:2] == '0)
                    begin
                        // zero and one are not prime, two and three are
                        prime_next = in_value[1];
                        state_next = ST_OUT;
                    end
                    else if (!in_value[0])
                    begin
                        prime_next = 1'b0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        prime_next = 1'b1;
                        state_next = ST_DIV;
                        div_start  = 1'b1;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    if (div_reg > quotient)
                    begin
                        // divisor passed the square root: no factor found
                        prime_next = 1'b1;
                        state_next = ST_OUT;
                    end
                    else if (remainder == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        div_next  = div_reg + VALUE_WIDTH'(2);
                        div_start = 1'b1;
                    end
                end
            end

            ST_OUT:
            begin
                // hold the result until the output register frees
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        m_tdata                  = '0;
        m_tdata[VALUE_WIDTH-1:0] = out_value_reg;
        m_tdata[VALUE_WIDTH]     = out_prime_reg;
    end

endmodule

/* src/tdpt_checker.sv */
// Port-level checks for trial_division_prime_test, with the bind that attaches them.
// Depends only on the top level's ports.
module tdpt_checker #(
    parameter int VALUE_WIDTH = 31
) (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    s_tvalid,
    input logic                                    s_tready,
    input logic                                    m_tvalid,
    input logic                                    m_tready,
    input logic [((VALUE_WIDTH + 8) / 8) * 8 - 1:0] m_tdata
);

    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The block is not ready in the cycle after taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after accepting an item");

    // Zero and one are never flagged prime
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[VALUE_WIDTH-1:1] == '0) |-> !m_tdata[VALUE_WIDTH])
        else $error("value below two flagged prime");

    // Even values of four and up are never flagged prime
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] && (m_tdata[VALUE_WIDTH-1:2] != '0)
        |-> !m_tdata[VALUE_WIDTH])
        else $error("even value flagged prime");

endmodule

bind trial_division_prime_test tdpt_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_tdpt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* bench/tb.sv */
// Self-checking bench for trial_division_prime_test: directed table, then random values.
// Depends only on the RTL under src/ (trial_division_prime_test, tdpt_div and tdpt_pkg).
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW     = 31;
    localparam int S_BITS = ((VW + 7) / 8) * 8;   // 32: value, then zero pad
    localparam int M_BITS = ((VW + 8) / 8) * 8;   // 32: tested_value, is_prime

    // One result as the block should return it
    typedef struct packed {
        logic [VW-1:0] value;
        logic          prime;
    } verdict_t;

    // One row of the directed table; known = 1 means the verdict is typed in
    typedef struct {
        logic [S_BITS-1:0] data;
        bit                known;
        logic [VW-1:0]     value;
        logic              prime;
    } probe_row_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [S_BITS-1:0] s_tdata;    // value
    logic              m_tvalid;
    logic              m_tready;
    logic [M_BITS-1:0] m_tdata;    // tested_value, is_prime

    verdict_t   pending_results[$];
    int         errors;
    bit         steady;            // suppresses idling on both sides
    probe_row_t probes[$];

    trial_division_prime_test #(
        .VALUE_WIDTH(VW)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Trial division up to the square root; the bound is written as d <= v / d
    // so no product is ever formed.
    function automatic logic prime_verdict(input logic [VW-1:0] v);
        longint unsigned n;
        longint unsigned d;
        n = v;
        if (n < 2)
            return 1'b0;
        if (n < 4)
            return 1'b1;
        if (n % 2 == 0)
            return 1'b0;
        for (d = 3; d <= n / d; d += 2)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Draw a value. Keep most of them small: the divider runs one pass per odd
    // divisor up to sqrt(v) on a large prime. Large values are forced to carry a
    // small factor so they finish after a handful of divisors.
    function automatic logic [S_BITS-1:0] random_value();
        logic [S_BITS-1:0] r;
        int unsigned       tier;
        int unsigned       f;
        tier = $urandom_range(99);
        if (tier < 75)
            r = $urandom_range(16383);
        else if (tier < 80)
            r = $urandom_range(1048575);
        else
        begin
            r = $urandom() & 32'h7FFF_FFFF;
            case ($urandom_range(3))
                0: f = 2;
                1: f = 3;
                2: f = 5;
                default: f = 7;
            endcase
            r = r - (r % f);
        end
        // Set the pad bit now and then; the block must ignore it
        if ($urandom_range(9) == 0)
            r[S_BITS-1] = 1'b1;
        return r;
    endfunction

    // Offer one item, entered and left at a falling edge. Do not lower tvalid
    // here: the next call or the end of stimulus decides, so that tvalid sees
    // at most one assignment per edge.
    task automatic send_value(input logic [S_BITS-1:0] data, input bit known,
                              input verdict_t typed);
        verdict_t v;
        while (!steady && $urandom_range(99) < 13)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        // Accepted at this edge: queue the verdict
        if (known)
            v = typed;
        else
        begin
            v.value = data[VW-1:0];
            v.prime = prime_verdict(data[VW-1:0]);
        end
        pending_results.push_back(v);
        @(negedge clk);
    endtask

    // Hold the sender until every queued verdict has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic void add_probe(input logic [S_BITS-1:0] data, input bit known,
                                      input logic [VW-1:0] value, input logic prime);
        probe_row_t p;
        p.data  = data;
        p.known = known;
        p.value = value;
        p.prime = prime;
        probes.push_back(p);
    endfunction

    // Receiver: stall at random except during the steady stretch
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= steady || ($urandom_range(99) >= 13);
    end

    // Checker: compare each returned item with the oldest verdict
    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result value=%0d prime=%0b", $realtime,
                         m_tdata[VW-1:0], m_tdata[VW]);
                errors++;
            end
            else
            begin
                exp_v = pending_results.pop_front();
                if (m_tdata[VW-1:0] !== exp_v.value)
                begin
                    $display("%0t: tested_value expected %0d actual %0d", $realtime,
                             exp_v.value, m_tdata[VW-1:0]);
                    errors++;
                end
                if (m_tdata[VW] !== exp_v.prime)
                begin
                    $display("%0t: is_prime of %0d expected %0b actual %0b", $realtime,
                             exp_v.value, exp_v.prime, m_tdata[VW]);
                    errors++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        verdict_t typed;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        errors   = 0;
        steady   = 1'b0;

        // Directed table: verdicts typed in where they are obvious
        add_probe(32'd0,          1, 31'd0,          1'b0);  // zero
        add_probe(32'd1,          1, 31'd1,          1'b0);  // one
        add_probe(32'd2,          1, 31'd2,          1'b1);  // two, no divisor in range
        add_probe(32'd3,          1, 31'd3,          1'b1);  // three, no divisor in range
        add_probe(32'd4,          1, 31'd4,          1'b0);  // smallest even composite
        add_probe(32'd5,          0, '0,             1'b0);
        add_probe(32'd9,          0, '0,             1'b0);  // square of a prime
        add_probe(32'd25,         0, '0,             1'b0);
        add_probe(32'd49,         0, '0,             1'b0);
        add_probe(32'd97,         0, '0,             1'b0);
        add_probe(32'd65521,      0, '0,             1'b0);  // largest 16-bit prime
        add_probe(32'd65537,      0, '0,             1'b0);
        add_probe(32'd60491,      0, '0,             1'b0);  // 241 * 251
        add_probe(32'd1000003,    0, '0,             1'b0);
        add_probe(32'h5555_5555,  0, '0,             1'b0);
        add_probe(32'h2AAA_AAAA,  0, '0,             1'b0);
        add_probe(32'h8000_0005,  1, 31'd5,          1'b1);  // pad bit must be ignored
        add_probe(32'hFFFF_FFFE,  1, 31'h7FFF_FFFE,  1'b0);  // pad bit, even maximum
        add_probe(32'h7FFF_FFFE,  1, 31'h7FFF_FFFE,  1'b0);
        add_probe(32'h7FFF_FFFF,  1, 31'h7FFF_FFFF,  1'b1);  // largest value, a prime

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (probes[i])
        begin
            typed.value = probes[i].value;
            typed.prime = probes[i].prime;
            send_value(probes[i].data, probes[i].known, typed);
            // Let everything drain once, mid-table
            if (i == 9)
                drain_results();
        end

        typed = '0;
        for (int n = 0; n < 80; n++)
        begin
            steady = (n >= 30 && n < 50);
            if ($urandom_range(19) == 0)
                drain_results();
            send_value(random_value(), 0, typed);
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: fails the run if it does not finish in time; the slowest item is the largest prime
    initial
    begin
        #160_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
src/tdpt_pkg.sv
src/tdpt_div.sv
src/trial_division_prime_test.sv
src/tdpt_checker.sv
bench/tb.sv
